// File: hw/rtl/srt_pkg.sv
package srt_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_CMP,
        ST_APPLY
    } t_state;

    typedef struct packed {
        t_mode       mode;
        logic [63:0] range_start;
        logic [63:0] range_length;
        logic [2:0]  protection;
        logic [2:0]  backing_kind;
        logic [63:0] backing_offset;
        logic [3:0]  entry_index;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [4:0]  entry_count;
        logic        entry_valid;
        logic [63:0] entry_start;
        logic [63:0] entry_end;
        logic [2:0]  entry_protection;
        logic [2:0]  entry_kind;
        logic [63:0] entry_offset;
    } t_out_item;

    typedef struct packed {
        logic [63:0] start_addr;
        logic [63:0] end_addr;
        logic [2:0]  prot;
        logic [2:0]  kind;
        logic [63:0] offset;
    } t_entry;

    typedef struct packed {
        logic        cmp_en;
        logic        ins_en;
        logic [63:0] start_addr;
        logic [63:0] end_addr;
    } t_cell_ctl;

    typedef struct packed {
        logic less;
        logic overlap;
    } t_cell_flags;

endpackage

// File: hw/rtl/sorted_range_table.sv
// Sorted address-range table. One item is taken when start is high and busy
// is low; its result appears on o_result for exactly one cycle, marked by
// o_result_valid, and the receiver cannot hold it off. The steps of the
// control sequencer are: latch the item, form the range end and the
// empty/wrap/full checks, compare the new range against every entry of the
// cell row at once, then apply the insert (entries at and above the sorted
// position shift up one cell) or the clear, or select the entry to read.
// busy drops in the cycle the result is shown, so a new item may be started
// then. Reset clears the entry count, the sequencer state and the result
// strobe, not the entries; entries at or above the count are never visible.
module sorted_range_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  srt_pkg::t_in_item  i_item,
    output logic               o_result_valid,
    output srt_pkg::t_out_item o_result
);
    import srt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (CW > 4) ? CW : 4;
    localparam int RD = (TABLE_DEPTH < 16) ? TABLE_DEPTH : 16;

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    t_in_item    r_item;
    logic [63:0] r_end, n_end;
    logic        r_bad, n_bad;
    logic        r_done, n_done;
    t_out_item   r_result, n_result;

    t_cell_ctl   w_ctl;
    t_entry      w_new;
    t_entry      w_entry [TABLE_DEPTH];
    t_cell_flags w_flags [TABLE_DEPTH];

    logic [64:0] w_sum;
    logic        w_any_ovl;
    t_entry      w_sel;
    logic        w_found;

    assign w_new.start_addr = r_item.range_start;
    assign w_new.end_addr   = r_end;
    assign w_new.prot       = r_item.protection;
    assign w_new.kind       = r_item.backing_kind;
    assign w_new.offset     = r_item.backing_offset;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic   w_prev_less;
            t_entry w_prev;
            if (g == 0) begin : g_first
                assign w_prev_less = 1'b1;
                assign w_prev      = w_new;
            end else begin : g_rest
                assign w_prev_less = w_flags[g-1].less;
                assign w_prev      = w_entry[g-1];
            end
            srt_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_valid     (CW'(g) < r_count),
                .i_prev_less (w_prev_less),
                .i_prev      (w_prev),
                .i_new       (w_new),
                .o_entry     (w_entry[g]),
                .o_flags     (w_flags[g])
            );
        end
    endgenerate

    always_comb begin
        w_any_ovl = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w_any_ovl = w_any_ovl | w_flags[k].overlap;
        end
        w_sel   = '0;
        w_found = 1'b0;
        for (int k = 0; k < RD; k++) begin
            if (r_item.entry_index == 4'(k)) begin
                w_sel   = w_entry[k];
                w_found = 1'b1;
            end
        end
    end

    assign w_sum = {1'b0, r_item.range_start} + {1'b0, r_item.range_length};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        if (r_state == ST_IDLE && start) begin
            r_item <= i_item;
        end
        r_end    <= n_end;
        r_bad    <= n_bad;
        r_result <= n_result;
    end

    always_comb begin
        n_state          = r_state;
        n_count          = r_count;
        n_end            = r_end;
        n_bad            = r_bad;
        n_done           = 1'b0;
        n_result         = r_result;
        w_ctl.cmp_en     = 1'b0;
        w_ctl.ins_en     = 1'b0;
        w_ctl.start_addr = r_item.range_start;
        w_ctl.end_addr   = r_end;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_end   = w_sum[63:0];
                n_bad   = (r_item.range_length == 64'd0) || w_sum[64]
                          || (r_count >= CW'(TABLE_DEPTH));
                n_state = ST_CMP;
            end
            ST_CMP: begin
                w_ctl.cmp_en = 1'b1;
                n_state      = ST_APPLY;
            end
            ST_APPLY: begin
                n_result = '0;
                case (r_item.mode)
                    MODE_CLEAR: begin
                        n_count = '0;
                    end
                    MODE_INSERT: begin
                        if (r_bad || w_any_ovl) begin
                            n_result.status = 1'b1;
                        end else begin
                            w_ctl.ins_en = 1'b1;
                            n_count      = r_count + CW'(1);
                        end
                    end
                    MODE_READ: begin
                        if (w_found && (IW'(r_item.entry_index) < IW'(r_count))) begin
                            n_result.entry_valid      = 1'b1;
                            n_result.entry_start      = w_sel.start_addr;
                            n_result.entry_end        = w_sel.end_addr;
                            n_result.entry_protection = w_sel.prot;
                            n_result.entry_kind       = w_sel.kind;
                            n_result.entry_offset     = w_sel.offset;
                        end
                    end
                    default: begin
                    end
                endcase
                n_result.entry_count = 5'(n_count);
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_done;
    assign o_result       = r_result;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_result_valid)
        else $error("item taken without a result four cycles later");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == ST_APPLY))
        else $error("result strobe outside the apply step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(r_state == ST_APPLY))
        else $error("entry count changed outside the apply step");

endmodule

// File: hw/rtl/srt_cell.sv
module srt_cell (
    input  logic                i_clk,
    input  srt_pkg::t_cell_ctl  i_ctl,
    input  logic                i_valid,
    input  logic                i_prev_less,
    input  srt_pkg::t_entry     i_prev,
    input  srt_pkg::t_entry     i_new,
    output srt_pkg::t_entry     o_entry,
    output srt_pkg::t_cell_flags o_flags
);
    import srt_pkg::*;

    t_entry      r_entry;
    t_cell_flags r_flags;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_flags.less    <= i_valid && (r_entry.start_addr < i_ctl.start_addr);
            r_flags.overlap <= i_valid && (i_ctl.start_addr < r_entry.end_addr)
                               && (r_entry.start_addr < i_ctl.end_addr);
        end
        // entries at or above the insert point take the new range or shift up
        if (i_ctl.ins_en && !r_flags.less) begin
            r_entry <= i_prev_less ? i_new : i_prev;
        end
    end

    assign o_entry = r_entry;
    assign o_flags = r_flags;

endmodule

// File: dv/testbench.sv
module testbench;
    import srt_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 360;
    localparam logic [63:0] ALL_ONES = '1;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [2:0]  prot;
        logic [2:0]  kind;
        logic [63:0] offs;
    } range_rec_t;

    typedef struct {
        t_in_item  item;
        bit        fixed_want;
        t_out_item want;
    } step_row_t;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_result_valid;
    t_out_item o_result;

    range_rec_t held_ranges[DEPTH];
    int        held_num = 0;
    t_out_item pending_results[$];
    step_row_t dir_rows[$];
    int        fail_count = 0;
    int        cycle_count = 0;
    bit        no_gaps = 1'b0;

    sorted_range_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item item_of(t_mode m, logic [63:0] s, logic [63:0] l,
                                         logic [2:0] p, logic [2:0] k,
                                         logic [63:0] o, logic [3:0] idx);
        t_in_item r;
        r.mode           = m;
        r.range_start    = s;
        r.range_length   = l;
        r.protection     = p;
        r.backing_kind   = k;
        r.backing_offset = o;
        r.entry_index    = idx;
        return r;
    endfunction

    function automatic t_out_item result_of(logic st, logic [4:0] cnt, logic vld,
                                            logic [63:0] s, logic [63:0] e,
                                            logic [2:0] p, logic [2:0] k,
                                            logic [63:0] o);
        t_out_item r;
        r.status           = st;
        r.entry_count      = cnt;
        r.entry_valid      = vld;
        r.entry_start      = s;
        r.entry_end        = e;
        r.entry_protection = p;
        r.entry_kind       = k;
        r.entry_offset     = o;
        return r;
    endfunction

    // updates the table copy and returns what the block should answer
    function automatic t_out_item apply_to_table(t_in_item it);
        t_out_item   r;
        logic [63:0] e;
        int          pos;
        bit          ok;
        r = '0;
        e = it.range_start + it.range_length;
        case (it.mode)
            MODE_CLEAR: begin
                held_num = 0;
            end
            MODE_INSERT: begin
                ok = (it.range_length != 0) && (e >= it.range_start) && (held_num < DEPTH);
                for (int k = 0; k < held_num; k++) begin
                    if (it.range_start < held_ranges[k].hi && held_ranges[k].lo < e)
                        ok = 1'b0;
                end
                if (ok) begin
                    pos = 0;
                    while (pos < held_num && held_ranges[pos].lo < it.range_start)
                        pos++;
                    for (int k = held_num; k > pos; k--)
                        held_ranges[k] = held_ranges[k - 1];
                    held_ranges[pos] = '{it.range_start, e, it.protection,
                                         it.backing_kind, it.backing_offset};
                    held_num++;
                end else begin
                    r.status = 1'b1;
                end
            end
            MODE_READ: begin
                if (it.entry_index < held_num) begin
                    r.entry_valid      = 1'b1;
                    r.entry_start      = held_ranges[it.entry_index].lo;
                    r.entry_end        = held_ranges[it.entry_index].hi;
                    r.entry_protection = held_ranges[it.entry_index].prot;
                    r.entry_kind       = held_ranges[it.entry_index].kind;
                    r.entry_offset     = held_ranges[it.entry_index].offs;
                end
            end
            default: ;
        endcase
        r.entry_count = held_num[4:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (fail_count < 50)
            $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
        fail_count++;
    endtask

    task automatic send_item(t_in_item it, bit fixed_want, t_out_item want);
        t_out_item pred;
        int        gap;
        i_item <= it;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = apply_to_table(it);
        pending_results.push_back(fixed_want ? want : pred);
        gap = $urandom_range(0, 99);
        if (no_gaps || gap < 60)
            gap = 0;
        else if (gap < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(4, 30);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_result[63:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", 64'(o_result.status), 64'(want.status));
                if (o_result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(o_result.entry_count),
                                    64'(want.entry_count));
                if (o_result.entry_valid !== want.entry_valid)
                    report_mismatch("entry_valid", 64'(o_result.entry_valid),
                                    64'(want.entry_valid));
                if (o_result.entry_start !== want.entry_start)
                    report_mismatch("entry_start", o_result.entry_start, want.entry_start);
                if (o_result.entry_end !== want.entry_end)
                    report_mismatch("entry_end", o_result.entry_end, want.entry_end);
                if (o_result.entry_protection !== want.entry_protection)
                    report_mismatch("entry_protection", 64'(o_result.entry_protection),
                                    64'(want.entry_protection));
                if (o_result.entry_kind !== want.entry_kind)
                    report_mismatch("entry_kind", 64'(o_result.entry_kind),
                                    64'(want.entry_kind));
                if (o_result.entry_offset !== want.entry_offset)
                    report_mismatch("entry_offset", o_result.entry_offset, want.entry_offset);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item    it;
        logic [63:0] s;
        logic [63:0] len;
        logic [63:0] e;
        int          work_items;
        int          ops;
        int          pick;
        int          j;
        bit          ok;

        // no operation and empty-table reads
        dir_rows.push_back('{item_of(MODE_NOP, ALL_ONES, ALL_ONES, 3'h7, 3'h7, ALL_ONES, 4'hf),
                             1'b1, result_of(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_READ, 0, 0, 0, 0, 0, 4'hf),
                             1'b1, result_of(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_READ, 0, 0, 0, 0, 0, 4'h0),
                             1'b1, result_of(0, 0, 0, 0, 0, 0, 0, 0)});
        // zero length, wrap, end exactly at 2^64, then two good inserts
        dir_rows.push_back('{item_of(MODE_INSERT, 64'h1000, 0, 3'h1, 3'h1, 0, 0),
                             1'b1, result_of(1, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, 0, 0, 0, 0),
                             1'b1, result_of(1, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10, 0, 0, 0, 0),
                             1'b1, result_of(1, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 64'hFF, 3'h7, 3'h7,
                                     ALL_ONES, 0),
                             1'b1, result_of(0, 1, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_INSERT, 0, 64'h100, 0, 0, 0, 0),
                             1'b1, result_of(0, 2, 0, 0, 0, 0, 0, 0)});
        // overlaps: inside, last byte, identical start; an adjacent insert and a wrapping one
        dir_rows.push_back('{item_of(MODE_INSERT, 64'h80, 64'h10, 3'h5, 3'h2, 64'h9, 0),
                             1'b1, result_of(1, 2, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_INSERT, 64'hFF, 64'h1, 0, 0, 0, 0),
                             1'b1, result_of(1, 2, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_INSERT, 64'h100, 64'h1, 3'h3, 3'h4, 64'h1234, 0),
                             1'b1, result_of(0, 3, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_INSERT, 0, 64'h100, 0, 0, 0, 0),
                             1'b1, result_of(1, 3, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_INSERT, 64'h10, ALL_ONES, 0, 0, 0, 0),
                             1'b1, result_of(1, 3, 0, 0, 0, 0, 0, 0)});
        // adjacent fills between the ends of the address space, one overlap, then reads and a clear
        dir_rows.push_back('{item_of(MODE_INSERT, 64'h8000_0000_0000_0000,
                                     64'h7FFF_FFFF_FFFF_FF00, 3'h6, 3'h1,
                                     64'h5555_5555_5555_5555, 0), 1'b0, '0});
        dir_rows.push_back('{item_of(MODE_INSERT, 64'h101, 64'h7FFF_FFFF_FFFF_FEFF, 3'h2, 3'h5,
                                     64'hAAAA_AAAA_AAAA_AAAA, 0), 1'b0, '0});
        dir_rows.push_back('{item_of(MODE_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h2, 0, 0, 0, 0),
                             1'b0, '0});
        dir_rows.push_back('{item_of(MODE_READ, 0, 0, 0, 0, 0, 4'h0),
                             1'b1, result_of(0, 5, 1, 0, 64'h100, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_READ, 0, 0, 0, 0, 0, 4'h4),
                             1'b1, result_of(0, 5, 1, 64'hFFFF_FFFF_FFFF_FF00, ALL_ONES,
                                             3'h7, 3'h7, ALL_ONES)});
        dir_rows.push_back('{item_of(MODE_READ, 0, 0, 0, 0, 0, 4'h1), 1'b0, '0});
        dir_rows.push_back('{item_of(MODE_READ, 0, 0, 0, 0, 0, 4'h2), 1'b0, '0});
        dir_rows.push_back('{item_of(MODE_READ, 0, 0, 0, 0, 0, 4'h3), 1'b0, '0});
        dir_rows.push_back('{item_of(MODE_READ, 0, 0, 0, 0, 0, 4'h5),
                             1'b1, result_of(0, 5, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_NOP, 0, 0, 0, 0, 0, 0),
                             1'b1, result_of(0, 5, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_CLEAR, ALL_ONES, ALL_ONES, 3'h7, 3'h7, ALL_ONES, 4'hf),
                             1'b1, result_of(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{item_of(MODE_READ, 0, 0, 0, 0, 0, 4'h0),
                             1'b1, result_of(0, 0, 0, 0, 0, 0, 0, 0)});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_item(dir_rows[r].item, dir_rows[r].fixed_want, dir_rows[r].want);

        work_items = 0;
        while (work_items < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) != 0) begin
                send_item(item_of(MODE_CLEAR, rand64(), rand64(), 3'($urandom),
                                  3'($urandom), rand64(), 4'($urandom)), 1'b0, '0);
                work_items++;
            end
            ops = $urandom_range(10, 40);
            repeat (ops) begin
                pick = $urandom_range(0, 99);
                it = item_of(MODE_INSERT, rand64(), rand64(), 3'($urandom), 3'($urandom),
                             rand64(), 4'($urandom));
                if (pick < 62) begin
                    // free range: random, just above or just below a held one
                    for (int t = 0; t < 8; t++) begin
                        len = rand64() >> $urandom_range(8, 63);
                        if (len == 0)
                            len = 1;
                        j = (held_num > 0) ? $urandom_range(0, held_num - 1) : 0;
                        case ($urandom_range(0, 2))
                            0: s = rand64();
                            1: s = (held_num > 0) ? held_ranges[j].hi : rand64();
                            default: s = (held_num > 0) ? held_ranges[j].lo - len : rand64();
                        endcase
                        e = s + len;
                        ok = (e > s);
                        for (int k = 0; k < held_num; k++) begin
                            if (s < held_ranges[k].hi && held_ranges[k].lo < e)
                                ok = 1'b0;
                        end
                        if (ok)
                            break;
                    end
                    it.range_start  = s;
                    it.range_length = len;
                end else if (pick < 74) begin
                    case ($urandom_range(0, 3))
                        0: it.range_length = 0;
                        1: ;
                        2: begin
                            if (held_num > 0) begin
                                j = $urandom_range(0, held_num - 1);
                                it.range_start  = held_ranges[j].hi
                                                  - 64'($urandom_range(1, 4));
                                it.range_length = 64'($urandom_range(1, 16));
                            end
                        end
                        default: begin
                            it.range_start  = ALL_ONES - 64'($urandom_range(0, 255));
                            it.range_length = 64'($urandom_range(1, 512));
                        end
                    endcase
                end else if (pick < 94) begin
                    it.mode = MODE_READ;
                    if (held_num > 0 && $urandom_range(0, 3) != 0)
                        it.entry_index = 4'($urandom_range(0, held_num - 1));
                end else if (pick < 98) begin
                    it.mode = MODE_NOP;
                end else begin
                    it.mode = MODE_CLEAR;
                end
                send_item(it, 1'b0, '0);
                if (it.mode != MODE_NOP)
                    work_items++;
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/srt_pkg.sv
hw/rtl/srt_cell.sv
hw/rtl/sorted_range_table.sv
dv/testbench.sv
